// ===== hw/rtl/blut_pkg.sv =====
// ----------------------------------------------------------------------------
// blut_pkg
// Shared types and constants of the bilinear map lookup block.
// ----------------------------------------------------------------------------
package blut_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned FracWidth  = 16;
  localparam int unsigned CountWidth = 5;
  localparam int unsigned IndexWidth = 4;

  // transaction opcodes
  localparam logic [1:0] OPC_ROW_BP    = 2'd0;
  localparam logic [1:0] OPC_COLUMN_BP = 2'd1;
  localparam logic [1:0] OPC_CELL      = 2'd2;
  localparam logic [1:0] OPC_LOOKUP    = 2'd3;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  // axis codes
  localparam logic AXIS_ROW    = 1'b0;
  localparam logic AXIS_COLUMN = 1'b1;

  // lerp slots
  localparam logic [1:0] LERP_LOW_ROW  = 2'd0;
  localparam logic [1:0] LERP_HIGH_ROW = 2'd1;
  localparam logic [1:0] LERP_FINAL    = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ_FIRST,
    OP_CHECK_FIRST,
    OP_CHECK_LAST,
    OP_SCAN,
    OP_DIVIDE,
    OP_CELL_READ,
    OP_CELL_LAST,
    OP_LERP_DIFF,
    OP_LERP_MUL,
    OP_LERP_ADD
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_FIRST,
    ST_CHECK_FIRST,
    ST_CHECK_LAST,
    ST_SCAN,
    ST_DIVIDE,
    ST_CELL0,
    ST_CELL1,
    ST_CELL2,
    ST_CELL3,
    ST_CELL_LAST,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic       axis;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic c_le_d;
    logic c_ge_d;
    logic div_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/blut_ctrl.sv =====
// ----------------------------------------------------------------------------
// blut_ctrl
// Sequencer of the lookup: axis searches, divisions, cell reads and lerps.
// ----------------------------------------------------------------------------
module blut_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  logic                 in_lookup_i,
  input  logic                 out_free_i,
  input  blut_pkg::dp_status_t status_i,
  output blut_pkg::dp_cmd_t    cmd_o,
  output logic                 in_ready_o,
  output logic                 out_load_o
);

  blut_pkg::ctl_state_e state_q, state_d;
  logic                 axis_q, axis_d;
  logic [1:0]           lerp_q, lerp_d;
  blut_pkg::ctl_state_e axis_done_state;
  logic                 axis_done_axis;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blut_pkg::ST_IDLE;
      axis_q  <= blut_pkg::AXIS_ROW;
      lerp_q  <= blut_pkg::LERP_LOW_ROW;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      lerp_q  <= lerp_d;
    end
  end

  // after one axis: go to the other axis or to the cells
  always_comb begin
    if (axis_q == blut_pkg::AXIS_ROW) begin
      axis_done_state = blut_pkg::ST_READ_FIRST;
      axis_done_axis  = blut_pkg::AXIS_COLUMN;
    end else begin
      axis_done_state = blut_pkg::ST_CELL0;
      axis_done_axis  = axis_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    lerp_d  = lerp_q;
    case (state_q)
      blut_pkg::ST_IDLE: begin
        if (in_accept_i && in_lookup_i) begin
          state_d = blut_pkg::ST_READ_FIRST;
          axis_d  = blut_pkg::AXIS_ROW;
        end
      end
      blut_pkg::ST_READ_FIRST: state_d = blut_pkg::ST_CHECK_FIRST;
      blut_pkg::ST_CHECK_FIRST: begin
        if (status_i.c_le_d) begin
          state_d = axis_done_state;
          axis_d  = axis_done_axis;
        end else begin
          state_d = blut_pkg::ST_CHECK_LAST;
        end
      end
      blut_pkg::ST_CHECK_LAST: begin
        if (status_i.c_ge_d) begin
          state_d = axis_done_state;
          axis_d  = axis_done_axis;
        end else begin
          state_d = blut_pkg::ST_SCAN;
        end
      end
      blut_pkg::ST_SCAN: begin
        if (!status_i.c_ge_d) begin
          state_d = blut_pkg::ST_DIVIDE;
        end
      end
      blut_pkg::ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = axis_done_state;
          axis_d  = axis_done_axis;
        end
      end
      blut_pkg::ST_CELL0:     state_d = blut_pkg::ST_CELL1;
      blut_pkg::ST_CELL1:     state_d = blut_pkg::ST_CELL2;
      blut_pkg::ST_CELL2:     state_d = blut_pkg::ST_CELL3;
      blut_pkg::ST_CELL3:     state_d = blut_pkg::ST_CELL_LAST;
      blut_pkg::ST_CELL_LAST: begin
        state_d = blut_pkg::ST_DIFF;
        lerp_d  = blut_pkg::LERP_LOW_ROW;
      end
      blut_pkg::ST_DIFF: state_d = blut_pkg::ST_MUL;
      blut_pkg::ST_MUL:  state_d = blut_pkg::ST_ADD;
      blut_pkg::ST_ADD: begin
        if (lerp_q == blut_pkg::LERP_FINAL) begin
          state_d = blut_pkg::ST_OUT;
        end else begin
          state_d = blut_pkg::ST_DIFF;
          lerp_d  = lerp_q + 2'd1;
        end
      end
      blut_pkg::ST_OUT: begin
        if (out_free_i) begin
          state_d = blut_pkg::ST_IDLE;
        end
      end
      default: state_d = blut_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = blut_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    cmd_o.sel  = lerp_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      blut_pkg::ST_IDLE:        in_ready_o = 1'b1;
      blut_pkg::ST_READ_FIRST:  cmd_o.op = blut_pkg::OP_READ_FIRST;
      blut_pkg::ST_CHECK_FIRST: cmd_o.op = blut_pkg::OP_CHECK_FIRST;
      blut_pkg::ST_CHECK_LAST:  cmd_o.op = blut_pkg::OP_CHECK_LAST;
      blut_pkg::ST_SCAN:        cmd_o.op = blut_pkg::OP_SCAN;
      blut_pkg::ST_DIVIDE:      cmd_o.op = blut_pkg::OP_DIVIDE;
      blut_pkg::ST_CELL0: begin
        cmd_o.op  = blut_pkg::OP_CELL_READ;
        cmd_o.sel = 2'd0;
      end
      blut_pkg::ST_CELL1: begin
        cmd_o.op  = blut_pkg::OP_CELL_READ;
        cmd_o.sel = 2'd1;
      end
      blut_pkg::ST_CELL2: begin
        cmd_o.op  = blut_pkg::OP_CELL_READ;
        cmd_o.sel = 2'd2;
      end
      blut_pkg::ST_CELL3: begin
        cmd_o.op  = blut_pkg::OP_CELL_READ;
        cmd_o.sel = 2'd3;
      end
      blut_pkg::ST_CELL_LAST:   cmd_o.op = blut_pkg::OP_CELL_LAST;
      blut_pkg::ST_DIFF:        cmd_o.op = blut_pkg::OP_LERP_DIFF;
      blut_pkg::ST_MUL:         cmd_o.op = blut_pkg::OP_LERP_MUL;
      blut_pkg::ST_ADD:         cmd_o.op = blut_pkg::OP_LERP_ADD;
      blut_pkg::ST_OUT:         out_load_o = out_free_i;
      default:                  cmd_o.op = blut_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== hw/rtl/blut_datapath.sv =====
// ----------------------------------------------------------------------------
// blut_datapath
// Breakpoint and cell memories, search registers, divider and lerp unit.
// ----------------------------------------------------------------------------
module blut_datapath #(
  parameter int unsigned MAX_ROWS    = 16,
  parameter int unsigned MAX_COLUMNS = 16
) (
  input  logic                 clk_i,
  input  blut_pkg::dp_cmd_t    cmd_i,
  input  logic                 accept_i,
  input  logic [1:0]           opcode_i,
  input  logic [3:0]           row_index_i,
  input  logic [3:0]           column_index_i,
  input  logic signed [31:0]   write_value_i,
  input  logic signed [31:0]   row_coordinate_i,
  input  logic signed [31:0]   column_coordinate_i,
  input  logic [4:0]           row_count_i,
  input  logic [4:0]           column_count_i,
  output blut_pkg::dp_status_t status_o,
  output logic signed [31:0]   result_o
);

  localparam int unsigned RIW   = $clog2(MAX_ROWS);
  localparam int unsigned CIW   = $clog2(MAX_COLUMNS);
  localparam int unsigned IW    = (RIW > CIW) ? RIW : CIW;
  localparam int unsigned CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned CAW   = $clog2(CELLS);

  logic signed [31:0] row_bp_mem [MAX_ROWS];
  logic signed [31:0] col_bp_mem [MAX_COLUMNS];
  logic signed [31:0] cell_mem   [CELLS];

  logic signed [31:0] row_rd_q, col_rd_q, cell_rd_q;
  logic signed [31:0] row_coord_q, col_coord_q;
  logic signed [31:0] prev_q;
  logic [IW-1:0]      idx_q;
  logic [RIW-1:0]     rlo_q, rhi_q;
  logic [CIW-1:0]     clo_q, chi_q;
  logic [15:0]        rfrac_q, cfrac_q;
  logic [31:0]        rem_q, den_q;
  logic [15:0]        quo_q;
  logic [3:0]         div_cnt_q;
  logic signed [31:0] v_q [4];
  logic signed [31:0] a_q;
  logic signed [32:0] diff_q;
  logic signed [49:0] prod_q;
  logic signed [31:0] result_q;

  logic [IW-1:0]      row_last, col_last, last, bp_addr;
  logic signed [31:0] c, d;
  logic [32:0]        num_full, den_full, rem_shift;
  logic               div_ge;
  logic [RIW-1:0]     cell_r;
  logic [CIW-1:0]     cell_c;
  logic [CAW-1:0]     cell_rd_addr, cell_wr_addr;
  logic signed [31:0] lerp_a, lerp_b;
  logic [15:0]        lerp_f;
  logic signed [33:0] lerp_sum;

  // clamped last in-use index per axis
  always_comb begin
    if (row_count_i < 5'd2) begin
      row_last = IW'(1);
    end else if (32'(row_count_i) > MAX_ROWS) begin
      row_last = IW'(MAX_ROWS - 1);
    end else begin
      row_last = IW'(row_count_i - 5'd1);
    end
    if (column_count_i < 5'd2) begin
      col_last = IW'(1);
    end else if (32'(column_count_i) > MAX_COLUMNS) begin
      col_last = IW'(MAX_COLUMNS - 1);
    end else begin
      col_last = IW'(column_count_i - 5'd1);
    end
  end

  assign last = cmd_i.axis ? col_last : row_last;
  assign c    = cmd_i.axis ? col_coord_q : row_coord_q;
  assign d    = cmd_i.axis ? col_rd_q : row_rd_q;

  assign status_o.c_le_d   = (c <= d);
  assign status_o.c_ge_d   = (c >= d);
  assign status_o.div_last = (div_cnt_q == 4'd15);

  always_comb begin
    case (cmd_i.op)
      blut_pkg::OP_CHECK_FIRST: bp_addr = last;
      blut_pkg::OP_CHECK_LAST:  bp_addr = IW'(1);
      blut_pkg::OP_SCAN:        bp_addr = idx_q + IW'(1);
      default:                  bp_addr = '0;
    endcase
  end

  // breakpoint memories
  always_ff @(posedge clk_i) begin
    if (accept_i && opcode_i == blut_pkg::OPC_ROW_BP && 32'(row_index_i) < MAX_ROWS) begin
      row_bp_mem[RIW'(row_index_i)] <= write_value_i;
    end
    row_rd_q <= row_bp_mem[RIW'(bp_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && opcode_i == blut_pkg::OPC_COLUMN_BP &&
        32'(column_index_i) < MAX_COLUMNS) begin
      col_bp_mem[CIW'(column_index_i)] <= write_value_i;
    end
    col_rd_q <= col_bp_mem[CIW'(bp_addr)];
  end

  // cell memory, row-major
  always_comb begin
    cell_r = cmd_i.sel[1] ? rhi_q : rlo_q;
    cell_c = cmd_i.sel[0] ? chi_q : clo_q;
  end

  assign cell_rd_addr = CAW'(cell_r) * CAW'(MAX_COLUMNS) + CAW'(cell_c);
  assign cell_wr_addr = CAW'(RIW'(row_index_i)) * CAW'(MAX_COLUMNS) +
                        CAW'(CIW'(column_index_i));

  always_ff @(posedge clk_i) begin
    if (accept_i && opcode_i == blut_pkg::OPC_CELL && 32'(row_index_i) < MAX_ROWS &&
        32'(column_index_i) < MAX_COLUMNS) begin
      cell_mem[cell_wr_addr] <= write_value_i;
    end
    cell_rd_q <= cell_mem[cell_rd_addr];
  end

  // interval search and division
  assign num_full  = {c[31], c} - {prev_q[31], prev_q};
  assign den_full  = {d[31], d} - {prev_q[31], prev_q};
  assign rem_shift = {rem_q, 1'b0};
  assign div_ge    = (rem_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (accept_i && opcode_i == blut_pkg::OPC_LOOKUP) begin
      row_coord_q <= row_coordinate_i;
      col_coord_q <= column_coordinate_i;
    end
    case (cmd_i.op)
      blut_pkg::OP_CHECK_FIRST: begin
        prev_q <= d;
        if (status_o.c_le_d) begin
          if (cmd_i.axis) begin
            clo_q   <= '0;
            chi_q   <= '0;
            cfrac_q <= '0;
          end else begin
            rlo_q   <= '0;
            rhi_q   <= '0;
            rfrac_q <= '0;
          end
        end
      end
      blut_pkg::OP_CHECK_LAST: begin
        idx_q <= IW'(1);
        if (status_o.c_ge_d) begin
          if (cmd_i.axis) begin
            clo_q   <= CIW'(last);
            chi_q   <= CIW'(last);
            cfrac_q <= '0;
          end else begin
            rlo_q   <= RIW'(last);
            rhi_q   <= RIW'(last);
            rfrac_q <= '0;
          end
        end
      end
      blut_pkg::OP_SCAN: begin
        if (!status_o.c_ge_d) begin
          if (cmd_i.axis) begin
            chi_q <= CIW'(idx_q);
            clo_q <= CIW'(idx_q - IW'(1));
          end else begin
            rhi_q <= RIW'(idx_q);
            rlo_q <= RIW'(idx_q - IW'(1));
          end
          rem_q     <= num_full[31:0];
          den_q     <= den_full[31:0];
          quo_q     <= '0;
          div_cnt_q <= '0;
        end else begin
          prev_q <= d;
          idx_q  <= idx_q + IW'(1);
        end
      end
      blut_pkg::OP_DIVIDE: begin
        rem_q     <= div_ge ? 32'(rem_shift - {1'b0, den_q}) : rem_shift[31:0];
        quo_q     <= {quo_q[14:0], div_ge};
        div_cnt_q <= div_cnt_q + 4'd1;
        if (status_o.div_last) begin
          if (cmd_i.axis) begin
            cfrac_q <= {quo_q[14:0], div_ge};
          end else begin
            rfrac_q <= {quo_q[14:0], div_ge};
          end
        end
      end
      default: ;
    endcase
  end

  // lerp operand selection
  always_comb begin
    case (cmd_i.sel)
      blut_pkg::LERP_LOW_ROW: begin
        lerp_a = v_q[0];
        lerp_b = v_q[1];
        lerp_f = cfrac_q;
      end
      blut_pkg::LERP_HIGH_ROW: begin
        lerp_a = v_q[2];
        lerp_b = v_q[3];
        lerp_f = cfrac_q;
      end
      default: begin
        lerp_a = v_q[0];
        lerp_b = v_q[2];
        lerp_f = rfrac_q;
      end
    endcase
  end

  // floor of the scaled product is an arithmetic shift
  assign lerp_sum = {{2{a_q[31]}}, a_q} + prod_q[49:16];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      blut_pkg::OP_CELL_READ: begin
        if (cmd_i.sel != 2'd0) begin
          v_q[cmd_i.sel - 2'd1] <= cell_rd_q;
        end
      end
      blut_pkg::OP_CELL_LAST: v_q[3] <= cell_rd_q;
      blut_pkg::OP_LERP_DIFF: begin
        a_q    <= lerp_a;
        diff_q <= 33'(lerp_b) - 33'(lerp_a);
      end
      blut_pkg::OP_LERP_MUL: prod_q <= 50'(diff_q * $signed({1'b0, lerp_f}));
      blut_pkg::OP_LERP_ADD: begin
        case (cmd_i.sel)
          blut_pkg::LERP_LOW_ROW:  v_q[0]   <= lerp_sum[31:0];
          blut_pkg::LERP_HIGH_ROW: v_q[2]   <= lerp_sum[31:0];
          default:                 result_q <= lerp_sum[31:0];
        endcase
      end
      default: ;
    endcase
  end

  assign result_o = result_q;

endmodule

// ===== hw/rtl/bilinear_table_lookup.sv =====
// ----------------------------------------------------------------------------
// bilinear_table_lookup
// Two-dimensional calibration map with bilinear interpolation.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): one transaction carries an opcode.
//   row breakpoint, column breakpoint and cell writes are stored when taken
//   and give no result; the block stays ready for the next transaction.
//   a lookup searches the row axis, then the column axis, reads the four
//   corner cells and runs three lerps through one shared multiplier.
//   per axis: the search stops at the first-breakpoint check when clamped
//   below, at the last-breakpoint check when clamped above, and otherwise
//   runs a linear scan over the breakpoint memory up to the interval's end,
//   then a 16-step restoring divider. then the cell reads, the lerps and the
//   result handover follow; in_ready_o is low for the whole lookup.
//   output channel (out_valid_o / out_ready_i): the result sits in an
//   output register, so the next transaction is taken while it waits; a
//   finished lookup waits in its last state until that register is free.
//   configuration (cfg_we_i): row_count and column_count. the user must
//   write them only while the block is idle; the block does not enforce it.
//   reset sets both counts to 2 and drops the output; memories have no reset.
// ----------------------------------------------------------------------------
module bilinear_table_lookup #(
  parameter int unsigned MAX_ROWS    = 16,
  parameter int unsigned MAX_COLUMNS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         row_index_i,
  input  logic [3:0]         column_index_i,
  input  logic signed [31:0] write_value_i,
  input  logic signed [31:0] row_coordinate_i,
  input  logic signed [31:0] column_coordinate_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] interpolated_value_o
);

  logic [4:0]           row_count_q, column_count_q;
  logic                 out_valid_q;
  logic signed [31:0]   out_value_q;
  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  blut_pkg::dp_cmd_t    cmd;
  blut_pkg::dp_status_t status;
  logic signed [31:0]   result;

  assign in_accept = in_valid_i && in_ready_o;
  // output register is free when empty or drained in this cycle
  assign out_free  = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 5'd2;
      column_count_q <= 5'd2;
    end else if (cfg_we_i) begin
      if (cfg_index_i == blut_pkg::CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i;
      end else begin
        column_count_q <= cfg_data_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign interpolated_value_o = out_value_q;

  blut_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_lookup_i (opcode_i == blut_pkg::OPC_LOOKUP),
    .out_free_i  (out_free),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_load_o  (out_load)
  );

  blut_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk_i               (clk_i),
    .cmd_i               (cmd),
    .accept_i            (in_accept),
    .opcode_i            (opcode_i),
    .row_index_i         (row_index_i),
    .column_index_i      (column_index_i),
    .write_value_i       (write_value_i),
    .row_coordinate_i    (row_coordinate_i),
    .column_coordinate_i (column_coordinate_i),
    .row_count_i         (row_count_q),
    .column_count_i      (column_count_q),
    .status_o            (status),
    .result_o            (result)
  );

endmodule

// ===== hw/rtl/blut_checker.sv =====
// ----------------------------------------------------------------------------
// blut_checker
// Port-level checks of the bilinear map lookup, bound to the top level.
// ----------------------------------------------------------------------------
module blut_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         opcode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] interpolated_value_o
);

  // a held result keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(interpolated_value_o))
    else $error("result changed while stalled");

  // a lookup makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == blut_pkg::OPC_LOOKUP |=> !in_ready_o)
    else $error("ready after lookup transaction");

  // table writes complete at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i != blut_pkg::OPC_LOOKUP |=> in_ready_o)
    else $error("not ready after write transaction");

endmodule

bind bilinear_table_lookup blut_checker u_blut_checker (.*);

// ===== bench/bilinear_table_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// bilinear_table_lookup_tb
// Self-checking bench for the bilinear map lookup: loads breakpoint and cell
// tables, runs lookups under random idling on both channels, and compares
// every interpolated result against an in-bench prediction of the map.
// ----------------------------------------------------------------------------
module bilinear_table_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: mirrors the tables and the counts, queues predicted results
  class map_scoreboard;
    logic signed [31:0] row_bp [16];
    logic signed [31:0] col_bp [16];
    logic signed [31:0] cells [16][16];
    int unsigned nrows = 2;
    int unsigned ncols = 2;
    logic signed [31:0] pending [$];
    int errors = 0;

    function void set_count(logic idx, logic [4:0] val);
      int unsigned n;
      n = (val < 2) ? 2 : ((val > 16) ? 16 : val);
      if (idx == blut_pkg::CFG_ROW_COUNT) nrows = n;
      else ncols = n;
    endfunction

    // interval search and Q0.16 fraction on one axis
    function void locate(logic signed [31:0] bp [16], int unsigned n, longint c,
                         output int unsigned lo, output int unsigned hi,
                         output longint frac);
      int unsigned i;
      longint num, den;
      lo = 0; hi = 0; frac = 0;
      if (c <= bp[0]) return;
      if (c >= bp[n-1]) begin
        lo = n - 1; hi = n - 1;
        return;
      end
      for (i = 1; i < n; i++) if (bp[i] > c) break;
      if (i >= n) i = n - 1;
      hi = i; lo = i - 1;
      num = c - longint'(bp[i-1]);
      den = longint'(bp[i]) - longint'(bp[i-1]);
      if (num > 0 && den > 0) frac = (num * 65536) / den;
    endfunction

    function longint blend(longint a, longint b, longint f);
      return a + ((b - a) * f >>> 16);
    endfunction

    function void note_transaction(logic [1:0] op, logic [3:0] ri, logic [3:0] ci,
                                   logic signed [31:0] wv, logic signed [31:0] rc,
                                   logic signed [31:0] cc);
      int unsigned rl, rh, cl, chi;
      longint rf, cf, lowr, highr;
      case (op)
        blut_pkg::OPC_ROW_BP: row_bp[ri] = wv;
        blut_pkg::OPC_COLUMN_BP: col_bp[ci] = wv;
        blut_pkg::OPC_CELL: cells[ri][ci] = wv;
        default: begin
          locate(row_bp, nrows, rc, rl, rh, rf);
          locate(col_bp, ncols, cc, cl, chi, cf);
          lowr = blend(cells[rl][cl], cells[rl][chi], cf);
          highr = blend(cells[rh][cl], cells[rh][chi], cf);
          pending.push_back(32'(blend(lowr, highr, rf)));
        end
      endcase
    endfunction

    function void check_result(logic signed [31:0] got);
      logic signed [31:0] exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d", $realtime, got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        $display("%0t: interpolated_value expected %0d actual %0d",
                 $realtime, exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [3:0] row_index_i = '0;
  logic [3:0] column_index_i = '0;
  logic signed [31:0] write_value_i = '0;
  logic signed [31:0] row_coordinate_i = '0;
  logic signed [31:0] column_coordinate_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] interpolated_value_o;

  map_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 1'b0;  // long receiver stall in progress

  bilinear_table_lookup dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // accepted transactions and results, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        sb.note_transaction(opcode_i, row_index_i, column_index_i, write_value_i,
                            row_coordinate_i, column_coordinate_i);
        idle_cycles = 0;
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(interpolated_value_o);
        idle_cycles = 0;
      end
      if (idle_cycles > 5000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random ready, sometimes a long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= hold_off ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(logic [1:0] op, logic [3:0] ri, logic [3:0] ci,
                      logic [31:0] wv, logic [31:0] rc, logic [31:0] cc);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    row_index_i <= ri;
    column_index_i <= ci;
    write_value_i <= wv;
    row_coordinate_i <= rc;
    column_coordinate_i <= cc;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // wait until every lookup has returned, plus a settling margin
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_count(logic idx, logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_count(idx, val);
  endtask

  // sorted breakpoints with random spacing, then every cell when asked
  task automatic load_map(int unsigned scale, bit with_cells);
    logic signed [31:0] v;
    v = -$signed(32'($urandom_range(0, scale * 8)));
    for (int i = 0; i < 16; i++) begin
      send(blut_pkg::OPC_ROW_BP, 4'(i), 4'($urandom), v, $urandom, $urandom);
      v = v + $urandom_range(1, scale);
    end
    v = -$signed(32'($urandom_range(0, scale * 8)));
    for (int i = 0; i < 16; i++) begin
      send(blut_pkg::OPC_COLUMN_BP, 4'($urandom), 4'(i), v, $urandom, $urandom);
      v = v + $urandom_range(1, scale);
    end
    if (with_cells) begin
      for (int r = 0; r < 16; r++)
        for (int c = 0; c < 16; c++)
          send(blut_pkg::OPC_CELL, 4'(r), 4'(c), $urandom, $urandom, $urandom);
    end
  endtask

  function automatic logic [31:0] pick_coord(logic signed [31:0] bp [16], int unsigned n);
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom;
    if (k == 1) return bp[$urandom_range(0, n - 1)];
    return bp[0] + $urandom_range(0, bp[n-1] - bp[0] + 10);
  endfunction

  initial begin
    logic [31:0] rc, cc;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: full-range values, clamping, exact breakpoints
    send(blut_pkg::OPC_ROW_BP, 4'd0, 4'd15, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    send(blut_pkg::OPC_ROW_BP, 4'd1, 4'd0, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send(blut_pkg::OPC_COLUMN_BP, 4'd15, 4'd0, 32'h8000_0000, 32'h0, 32'h0);
    send(blut_pkg::OPC_COLUMN_BP, 4'd0, 4'd1, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send(blut_pkg::OPC_CELL, 4'd0, 4'd0, 32'h8000_0000, 32'h0, 32'h0);
    send(blut_pkg::OPC_CELL, 4'd0, 4'd1, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send(blut_pkg::OPC_CELL, 4'd1, 4'd0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    send(blut_pkg::OPC_CELL, 4'd1, 4'd1, 32'h8000_0000, 32'h0, 32'h0);
    send(blut_pkg::OPC_LOOKUP, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send(blut_pkg::OPC_LOOKUP, 4'h0, 4'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(blut_pkg::OPC_LOOKUP, 4'h5, 4'hA, 32'h0, 32'h0, 32'h0);
    send(blut_pkg::OPC_LOOKUP, 4'h0, 4'h0, 32'h0, 32'h7FFF_FFFE, 32'h8000_0001);
    send(blut_pkg::OPC_LOOKUP, 4'h0, 4'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000);
    // unsorted pair: equal breakpoints
    send(blut_pkg::OPC_ROW_BP, 4'd1, 4'd0, 32'h8000_0000, 32'h0, 32'h0);
    send(blut_pkg::OPC_LOOKUP, 4'h0, 4'h0, 32'h0, 32'h0, 32'h1234_5678);
    send(blut_pkg::OPC_LOOKUP, 4'h0, 4'h0, 32'h0, 32'h8000_0000, 32'h1234_5678);

    // phases over a range of table sizes, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      logic [4:0] nr, nc;
      drain();
      case (phase)
        0: begin nr = 5'd2; nc = 5'd16; end
        1: begin nr = 5'd16; nc = 5'd2; end
        2: begin nr = 5'd0; nc = 5'd31; end
        3: begin nr = 5'd1; nc = 5'd17; end
        default: begin nr = 5'($urandom_range(2, 16)); nc = 5'($urandom_range(0, 31)); end
      endcase
      write_count(blut_pkg::CFG_ROW_COUNT, nr);
      write_count(blut_pkg::CFG_COLUMN_COUNT, nc);
      load_map(phase[0] ? 32'h0004_0000 : 32'h0800_0000, phase == 0);
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering lookups
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 65; n++) begin
        rc = pick_coord(sb.row_bp, sb.nrows);
        cc = pick_coord(sb.col_bp, sb.ncols);
        if ($urandom_range(0, 9) == 0)
          send(blut_pkg::OPC_CELL, 4'($urandom), 4'($urandom), $urandom, $urandom,
               $urandom);
        else
          send(blut_pkg::OPC_LOOKUP, 4'($urandom), 4'($urandom), $urandom, rc, cc);
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== bilinear_table_lookup.f =====
hw/rtl/blut_pkg.sv
hw/rtl/blut_ctrl.sv
hw/rtl/blut_datapath.sv
hw/rtl/bilinear_table_lookup.sv
hw/rtl/blut_checker.sv
bench/bilinear_table_lookup_tb.sv
